>>> design/dxt_pkg.sv
// Package for the DXT3/DXT5 texture block decoder.
// Holds the shared types, register codes, queue sizing and the small arithmetic helpers.
// No dependencies.
`default_nettype none

package dxt_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [1:0] REG_ALPHA_MODE   = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic ALPHA_DXT3 = 1'b0;
   localparam logic ALPHA_DXT5 = 1'b1;

   localparam logic [12:0] IMAGE_DIM_RESET = 13'd4096;

   typedef struct packed {
      logic        mode;
      logic [12:0] width;
      logic [12:0] height;
   } dxt_cfg_type;

   typedef struct packed {
      logic [63:0] alpha_half;
      logic [63:0] color_half;
      logic [9:0]  block_col;
      logic [9:0]  block_row;
      logic [15:0] mask;
      logic        mode;
   } dxt_raw_type;

   typedef struct packed {
      logic [63:0]           alpha_half;
      logic [31:0]           color_idx;
      logic [9:0]            block_col;
      logic [9:0]            block_row;
      logic [15:0]           mask;
      logic                  mode;
      logic [2:0][7:0]       e0;
      logic [2:0][7:0]       e1;
      logic                  a_gt;
      logic [5:0][10:0]      asum;
   } dxt_mid_type;

   typedef struct packed {
      logic [63:0]           alpha_half;
      logic [31:0]           color_idx;
      logic [9:0]            block_col;
      logic [9:0]            block_row;
      logic [15:0]           mask;
      logic                  mode;
      logic [3:0][2:0][7:0]  pal;
      logic [7:0][7:0]       atab;
   } dxt_entry_type;

   typedef struct packed {
      logic              avail;
      logic [QCNT_W-1:0] level;
   } dxt_qstat_type;

   // v*255/31 = 8v + floor(7v/31); the second term uses a reciprocal multiply.
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0]  t;
      logic [16:0] q;
      t = 8'(v) * 8'd7;
      q = 17'(t) * 17'd265;
      return {v, 3'b000} + {4'b0000, q[16:13]};
   endfunction

   // v*255/63 = 4v + floor(v/21).
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] adj;
      if (v >= 6'd63) begin
         adj = 2'd3;
      end else if (v >= 6'd42) begin
         adj = 2'd2;
      end else if (v >= 6'd21) begin
         adj = 2'd1;
      end else begin
         adj = 2'd0;
      end
      return {v, 2'b00} + {6'b000000, adj};
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [20:0] q;
      q = 21'(n) * 21'd683;
      return q[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] n);
      logic [22:0] q;
      q = 23'(n) * 23'd3277;
      return q[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] n);
      logic [23:0] q;
      q = 24'(n) * 24'd4682;
      return q[22:15];
   endfunction

endpackage

`default_nettype wire

>>> design/dxt_front.sv
// Front end of the decoder: accepts a block, works out which pixels lie inside the image
// and builds the colour palette and alpha table over two stages. Depends on dxt_pkg.
`default_nettype none

module dxt_front
   import dxt_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [63:0]   alpha_half,
   input  wire logic [63:0]   color_half,
   input  wire logic [9:0]    block_col,
   input  wire logic [9:0]    block_row,
   input  wire dxt_cfg_type   cfg,
   input  wire dxt_qstat_type qstat,
   output logic               push,
   output dxt_entry_type      entry
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > 13) ? DIM_W : 13;
   localparam logic [CMP_W-1:0] MAX_DIM_V = CMP_W'(MAX_DIM);

   logic          accept;
   logic          a_v_ff, a_v_in;
   dxt_raw_type   a_ff, a_in;
   logic          b_v_ff, b_v_in;
   dxt_mid_type   b_ff, b_in;
   logic [11:0]   px_x, px_y;

   assign busy   = (qstat.level + QCNT_W'(a_v_ff) + QCNT_W'(b_v_ff)) >= QCNT_W'(QDEPTH);
   assign accept = start && !busy;

   always_comb begin
      a_v_in          = accept;
      a_in.alpha_half = alpha_half;
      a_in.color_half = color_half;
      a_in.block_col  = block_col;
      a_in.block_row  = block_row;
      a_in.mode       = cfg.mode;
      a_in.mask       = '0;
      px_x            = '0;
      px_y            = '0;
      for (int p = 0; p < 16; p++) begin
         px_x = {block_col, 2'(p)};
         px_y = {block_row, 2'(p >> 2)};
         a_in.mask[p] = (CMP_W'(px_x) < CMP_W'(cfg.width)) && (CMP_W'(px_x) < MAX_DIM_V) &&
                        (CMP_W'(px_y) < CMP_W'(cfg.height)) && (CMP_W'(px_y) < MAX_DIM_V);
      end
   end

   always_comb begin
      logic [7:0] a0;
      logic [7:0] a1;
      a0              = a_ff.alpha_half[7:0];
      a1              = a_ff.alpha_half[15:8];
      b_v_in          = a_v_ff && (|a_ff.mask);
      b_in.alpha_half = a_ff.alpha_half;
      b_in.color_idx  = a_ff.color_half[63:32];
      b_in.block_col  = a_ff.block_col;
      b_in.block_row  = a_ff.block_row;
      b_in.mask       = a_ff.mask;
      b_in.mode       = a_ff.mode;
      b_in.e0[0]      = expand5(a_ff.color_half[15:11]);
      b_in.e0[1]      = expand6(a_ff.color_half[10:5]);
      b_in.e0[2]      = expand5(a_ff.color_half[4:0]);
      b_in.e1[0]      = expand5(a_ff.color_half[31:27]);
      b_in.e1[1]      = expand6(a_ff.color_half[26:21]);
      b_in.e1[2]      = expand5(a_ff.color_half[20:16]);
      b_in.a_gt       = a0 > a1;
      for (int k = 1; k <= 6; k++) begin
         if (b_in.a_gt) begin
            b_in.asum[k-1] = 11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1);
         end else if (k <= 4) begin
            b_in.asum[k-1] = 11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1);
         end else begin
            b_in.asum[k-1] = '0;
         end
      end
   end

   always_comb begin
      push             = b_v_ff;
      entry.alpha_half = b_ff.alpha_half;
      entry.color_idx  = b_ff.color_idx;
      entry.block_col  = b_ff.block_col;
      entry.block_row  = b_ff.block_row;
      entry.mask       = b_ff.mask;
      entry.mode       = b_ff.mode;
      entry.pal[0]     = b_ff.e0;
      entry.pal[1]     = b_ff.e1;
      for (int c = 0; c < 3; c++) begin
         entry.pal[2][c] = div3({1'b0, b_ff.e0[c], 1'b0} + {2'b00, b_ff.e1[c]});
         entry.pal[3][c] = div3({2'b00, b_ff.e0[c]} + {1'b0, b_ff.e1[c], 1'b0});
      end
      entry.atab[0] = b_ff.alpha_half[7:0];
      entry.atab[1] = b_ff.alpha_half[15:8];
      if (b_ff.a_gt) begin
         for (int k = 1; k <= 6; k++) begin
            entry.atab[k+1] = div7(b_ff.asum[k-1]);
         end
      end else begin
         for (int k = 1; k <= 4; k++) begin
            entry.atab[k+1] = div5(b_ff.asum[k-1]);
         end
         entry.atab[6] = 8'h00;
         entry.atab[7] = 8'hFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
      if (a_v_in) begin
         a_ff <= a_in;
      end
      if (a_v_ff) begin
         b_ff <= b_in;
      end
   end

endmodule

`default_nettype wire

>>> design/dxt_queue.sv
// Short queue of decoded block descriptions between the front end and the pixel emitter.
// Depends on dxt_pkg.
`default_nettype none

module dxt_queue
   import dxt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dxt_entry_type push_entry,
   input  wire logic          pop,
   output dxt_entry_type      pop_entry,
   output dxt_qstat_type      qstat
);

   dxt_entry_type     mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign pop_entry   = mem[rd_ptr_ff];
   assign qstat.avail = count_ff != '0;
   assign qstat.level = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> design/dxt_back.sv
// Pixel emitter: walks the in-image pixels of one block at a time and drives one
// registered RGBA result per cycle. Depends on dxt_pkg.
`default_nettype none

module dxt_back
   import dxt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dxt_qstat_type qstat,
   input  wire dxt_entry_type q_entry,
   output logic               pop,
   output logic               rsp_valid,
   output logic [11:0]        rsp_pixel_x,
   output logic [11:0]        rsp_pixel_y,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [7:0]         rsp_alpha,
   output logic               rsp_last
);

   function automatic logic [3:0] lowest_set(input logic [15:0] m);
      logic [3:0] idx;
      idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (m[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   logic          cur_v_ff, cur_v_in;
   dxt_entry_type cur_ff;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   rest;
   logic [3:0]    pix;
   logic          finishing;
   logic [1:0]    ci;
   logic [5:0]    apos;
   logic [2:0]    aidx;
   logic [3:0]    anib;

   logic          valid_ff;
   logic [11:0]   x_ff, x_in;
   logic [11:0]   y_ff, y_in;
   logic [7:0]    r_ff, r_in;
   logic [7:0]    g_ff, g_in;
   logic [7:0]    b_ff, b_in;
   logic [7:0]    a_ff, a_in;
   logic          last_ff, last_in;

   always_comb begin
      pix       = lowest_set(rem_ff);
      rest      = rem_ff & (rem_ff - 16'd1);
      finishing = cur_v_ff && (rest == '0);
      pop       = qstat.avail && (!cur_v_ff || finishing);

      ci   = cur_ff.color_idx[{pix, 1'b0} +: 2];
      anib = cur_ff.alpha_half[{pix, 2'b00} +: 4];
      apos = 6'd16 + {2'b00, pix} + {1'b0, pix, 1'b0};
      aidx = cur_ff.alpha_half[apos +: 3];

      x_in    = {cur_ff.block_col, pix[1:0]};
      y_in    = {cur_ff.block_row, pix[3:2]};
      r_in    = cur_ff.pal[ci][0];
      g_in    = cur_ff.pal[ci][1];
      b_in    = cur_ff.pal[ci][2];
      a_in    = (cur_ff.mode == ALPHA_DXT3) ? {anib, anib} : cur_ff.atab[aidx];
      last_in = rest == '0;

      if (pop) begin
         cur_v_in = 1'b1;
         rem_in   = q_entry.mask;
      end else begin
         cur_v_in = cur_v_ff && !finishing;
         rem_in   = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cur_v_ff <= cur_v_in;
         valid_ff <= cur_v_ff;
      end
      rem_ff <= rem_in;
      if (pop) begin
         cur_ff <= q_entry;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      r_ff    <= r_in;
      g_ff    <= g_in;
      b_ff    <= b_in;
      a_ff    <= a_in;
      last_ff <= last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_pixel_x = x_ff;
   assign rsp_pixel_y = y_ff;
   assign rsp_red     = r_ff;
   assign rsp_green   = g_ff;
   assign rsp_blue    = b_ff;
   assign rsp_alpha   = a_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

>>> design/dxt_texture_block_decoder_unit.sv
// Top level of the DXT3/DXT5 texture block decoder with its configuration registers.
// Depends on dxt_pkg, dxt_front, dxt_queue and dxt_back.
//
// A block is taken at a clock edge where start is high and busy is low. The pixels of the
// block that lie inside the image leave in raster order, one per cycle on rsp_valid, with
// rsp_last on the final one; the receiver cannot stall them. A block holds the pixel
// emitter until its last pixel inside the image has left; blocks with no such pixel
// emit nothing and are dropped before the queue. Pixels pass the two front-end stages,
// the queue, the emitter's block register and its result registers. Busy rises once the
// blocks in the four-entry queue and the two front-end stages together number four, so
// blocks can be issued back to back until the emitter falls behind. The user writes
// the registers through the APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module dxt_texture_block_decoder_unit
   import dxt_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_alpha_half,
   input  wire logic [63:0] req_color_half,
   input  wire logic [9:0]  req_block_col,
   input  wire logic [9:0]  req_block_row,
   output logic             rsp_valid,
   output logic [11:0]      rsp_pixel_x,
   output logic [11:0]      rsp_pixel_y,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic          mode_ff, mode_in;
   logic [12:0]   width_ff, width_in;
   logic [12:0]   height_ff, height_in;
   logic          wr_en;
   dxt_cfg_type   cfg;
   dxt_qstat_type qstat;
   logic          push;
   logic          pop;
   dxt_entry_type push_entry;
   dxt_entry_type pop_entry;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_ALPHA_MODE:   mode_in   = pwdata[0];
            REG_IMAGE_WIDTH:  width_in  = pwdata[12:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ALPHA_MODE:   prdata = {31'd0, mode_ff};
         REG_IMAGE_WIDTH:  prdata = {19'd0, width_ff};
         REG_IMAGE_HEIGHT: prdata = {19'd0, height_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ALPHA_DXT5;
         width_ff  <= IMAGE_DIM_RESET;
         height_ff <= IMAGE_DIM_RESET;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   dxt_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .alpha_half (req_alpha_half),
      .color_half (req_color_half),
      .block_col  (req_block_col),
      .block_row  (req_block_row),
      .cfg        (cfg),
      .qstat      (qstat),
      .push       (push),
      .entry      (push_entry)
   );

   dxt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   dxt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .q_entry     (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .rsp_alpha   (rsp_alpha),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

>>> design/dxt_checker.sv
// Port-level checks for the texture block decoder, attached to its top level by a bind.
// Depends only on the ports of dxt_texture_block_decoder_unit.
`default_nettype none

module dxt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_last,
   input wire logic [11:0] rsp_pixel_x,
   input wire logic [11:0] rsp_pixel_y,
   input wire logic        pready
);

   // Reset empties the whole pipeline, so nothing leaves and a new transaction is welcome.
   assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("output or busy active straight after reset");

   // A block's pixels leave in an unbroken run that ends with the last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside the pixel run of a block");

   // Consecutive pixels of one block stay within the same 4x4 tile.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_pixel_x[11:2] == $past(rsp_pixel_x[11:2]) &&
                                 rsp_pixel_y[11:2] == $past(rsp_pixel_y[11:2]))
      else $error("pixel run left its tile before the last flag");

   // The configuration port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("configuration port stalled");

endmodule

bind dxt_texture_block_decoder_unit dxt_checker u_dxt_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_last    (rsp_last),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .pready      (pready)
);

`default_nettype wire
